// ----- hdl/afqa_pkg.sv -----
// Shared types and constants for the approximate four-quadrant arctangent.
// No dependencies.
package afqa_pkg;

    localparam int ANGLE_WIDTH = 16;

    // pi/4 scaled by 2^32
    localparam logic [63:0] QUARTER_PI_Q32 = 64'd3373259426;

    typedef struct packed {
        logic y_neg;
        logic x_neg;
        logic num_neg;
    } afqa_side_t;

endpackage

// ----- hdl/afqa_divider.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on afqa_pkg for the sideband struct carried along with each transaction.
module afqa_divider import afqa_pkg::*; #(
    parameter int DEN_WIDTH = 17,
    parameter int QUO_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DEN_WIDTH-1:0] in_mag,
    input  logic [DEN_WIDTH-1:0] in_den,
    input  afqa_side_t           in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [QUO_WIDTH-1:0] out_quo,
    output afqa_side_t           out_side
);

    logic                 vld_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] rem_reg  [QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg  [QUO_WIDTH];
    logic [QUO_WIDTH-1:0] quo_reg  [QUO_WIDTH];
    afqa_side_t           side_reg [QUO_WIDTH];
    logic [QUO_WIDTH:0]   rdy;

    assign rdy[QUO_WIDTH] = out_ready;

    for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_step
        logic                 vld_in;
        logic [DEN_WIDTH-1:0] den_in;
        logic [QUO_WIDTH-1:0] quo_in;
        afqa_side_t           side_in;
        logic [DEN_WIDTH-1:0] trial;
        logic                 take;
        logic [DEN_WIDTH-1:0] rem_next;
        logic [QUO_WIDTH-1:0] quo_next;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign side_in = in_side;
            assign trial   = in_mag;
        end else begin : g_next
            assign vld_in  = vld_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quo_in  = quo_reg[i-1];
            assign side_in = side_reg[i-1];
            assign trial   = {rem_reg[i-1][DEN_WIDTH-2:0], 1'b0};
        end

        assign take     = (trial >= den_in);
        assign rem_next = take ? (trial - den_in) : trial;
        assign quo_next = {quo_in[QUO_WIDTH-2:0], take};
        assign rdy[i]   = !vld_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && vld_in) begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QUO_WIDTH-1];
    assign out_quo   = quo_reg[QUO_WIDTH-1];
    assign out_side  = side_reg[QUO_WIDTH-1];

endmodule

// ----- hdl/approximate_four_quadrant_arctangent.sv -----
// Approximate four-quadrant arctangent: top level with operand, multiply and output stages.
// Depends on afqa_pkg and afqa_divider.
//
// Accepts one (y, x) transaction per clock unless m_ready stalls the pipeline, and returns
// the first-order atan2 estimate in radians scaled by 2^ANGLE_FRACTION_BITS. The pipeline
// has one operand stage, one divider stage per quotient bit, one multiply stage and one
// output stage. Throughput is one transaction per cycle when not stalled; each stage holds
// its data while stalled.
module approximate_four_quadrant_arctangent import afqa_pkg::*; #(
    parameter int SAMPLE_WIDTH        = 16,
    parameter int ANGLE_FRACTION_BITS = 13,
    parameter int RATIO_FRACTION_BITS = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_value,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ANGLE_WIDTH-1:0] m_angle
);

    localparam int DW = SAMPLE_WIDTH + 1;
    localparam int QW = RATIO_FRACTION_BITS + 1;
    localparam int RW = RATIO_FRACTION_BITS + 2;
    localparam int MW = ANGLE_FRACTION_BITS + 1;
    localparam int PW = RW + MW;
    localparam int IW = (ANGLE_FRACTION_BITS + 3 > ANGLE_WIDTH) ?
                        ANGLE_FRACTION_BITS + 3 : ANGLE_WIDTH;
    localparam int SH = 32 - ANGLE_FRACTION_BITS;

    localparam logic [63:0] C1_WIDE = (QUARTER_PI_Q32 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [63:0] C2_WIDE = (64'd3 * QUARTER_PI_Q32 + (64'd1 << (SH - 1))) >> SH;

    localparam logic signed [MW-1:0] C1_MUL = MW'(C1_WIDE);
    localparam logic signed [IW-1:0] C1     = IW'(C1_WIDE);
    localparam logic signed [IW-1:0] C2     = IW'(C2_WIDE);

    // operand stage
    logic signed [DW-1:0] y_ext;
    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] abs_y;
    logic signed [DW-1:0] num;
    logic        [DW-1:0] mag_next;
    logic        [DW-1:0] den_next;
    afqa_side_t           side_next;
    logic                 origin;

    logic                 op_vld_reg;
    logic        [DW-1:0] mag_reg;
    logic        [DW-1:0] den_reg;
    afqa_side_t           side_reg;
    logic                 div_in_ready;

    // divider output
    logic                 div_valid;
    logic                 div_ready;
    logic        [QW-1:0] div_quo;
    afqa_side_t           div_side;

    // multiply stage
    logic signed [RW-1:0] ratio;
    logic signed [PW-1:0] prod_next;
    logic                 mul_vld_reg;
    logic signed [PW-1:0] prod_reg;
    afqa_side_t           mul_side_reg;
    logic                 mul_ready;

    // output stage
    logic signed [PW-1:0] prod_shift;
    logic signed [IW-1:0] term;
    logic signed [IW-1:0] base;
    logic signed [IW-1:0] diff;
    logic signed [IW-1:0] angle_next;
    logic                 out_vld_reg;
    logic [ANGLE_WIDTH-1:0] angle_reg;
    logic                 out_ready;

    always_comb begin
        y_ext  = {s_y_value[SAMPLE_WIDTH-1], s_y_value};
        x_ext  = {s_x_value[SAMPLE_WIDTH-1], s_x_value};
        abs_y  = s_y_value[SAMPLE_WIDTH-1] ? -y_ext : y_ext;
        origin = (s_x_value == '0) && (s_y_value == '0);
        num    = s_x_value[SAMPLE_WIDTH-1] ? (x_ext + abs_y) : (x_ext - abs_y);
        if (s_x_value[SAMPLE_WIDTH-1]) begin
            den_next = abs_y - x_ext;
        end else begin
            den_next = x_ext + abs_y;
        end
        mag_next          = num[DW-1] ? -num : num;
        side_next.y_neg   = s_y_value[SAMPLE_WIDTH-1];
        side_next.x_neg   = s_x_value[SAMPLE_WIDTH-1];
        side_next.num_neg = num[DW-1];
        if (origin) begin
            mag_next          = DW'(1);
            den_next          = DW'(1);
            side_next.num_neg = 1'b1;
        end
    end

    assign s_ready = !op_vld_reg || div_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_vld_reg <= 1'b0;
        end else if (s_ready) begin
            op_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            mag_reg  <= mag_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    afqa_divider #(
        .DEN_WIDTH (DW),
        .QUO_WIDTH (QW)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (op_vld_reg),
        .in_ready  (div_in_ready),
        .in_mag    (mag_reg),
        .in_den    (den_reg),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_quo   (div_quo),
        .out_side  (div_side)
    );

    always_comb begin
        ratio     = div_side.num_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        prod_next = PW'(ratio) * PW'(C1_MUL);
    end

    assign div_ready = !mul_vld_reg || mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
        end else if (div_ready) begin
            mul_vld_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready && div_valid) begin
            prod_reg     <= prod_next;
            mul_side_reg <= div_side;
        end
    end

    always_comb begin
        prod_shift = prod_reg >>> RATIO_FRACTION_BITS;
        term       = IW'(prod_shift);
        base       = mul_side_reg.x_neg ? C2 : C1;
        diff       = base - term;
        angle_next = mul_side_reg.y_neg ? -diff : diff;
    end

    assign mul_ready = !out_vld_reg || out_ready;
    assign out_ready = m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (mul_ready) begin
            out_vld_reg <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_ready && mul_vld_reg) begin
            angle_reg <= angle_next[ANGLE_WIDTH-1:0];
        end
    end

    assign m_valid = out_vld_reg;
    assign m_angle = angle_reg;

endmodule
